// ===== hw/rtl/cdu_pkg.sv =====
// shared types, constants and tables for the civil date to unix seconds pipeline
`timescale 1ns / 1ps
package cdu_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned PROD_W = 26;
  localparam int unsigned DAYS_W = 22;
  localparam int unsigned TOD_W  = 17;
  localparam int unsigned TS_W   = 38;

  localparam logic [YEAR_W-1:0] FIRST_YEAR = 14'd1970;
  localparam logic [YEAR_W-1:0] LAST_YEAR  = 14'd9999;

  // ceil(2^19 / 100), also ceil(2^21 / 400)
  localparam logic [PROD_W-1:0] RECIP_100 = 26'd5243;
  localparam int unsigned       SH_100    = 19;
  localparam int unsigned       SH_400    = 21;

  localparam logic [23:0]       DAYS_BIAS   = 24'd719469;
  localparam logic [TS_W-1:0]   SEC_PER_DAY = 38'd86400;
  localparam logic [TOD_W-1:0]  SEC_PER_HR  = 17'd3600;
  localparam logic [TOD_W-1:0]  SEC_PER_MIN = 17'd60;

  localparam logic [3:0] MON_FEB = 4'd2;

  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [YEAR_W-1:0] year;
    logic [YEAR_W-1:0] yadj;
    logic [PROD_W-1:0] py;
    logic [PROD_W-1:0] pya;
    logic [3:0]        month;
    logic [3:0]        mp;
    logic [4:0]        day;
    logic [TOD_W-1:0]  tod;
  } s1_t;

  typedef struct packed {
    logic              vld;
    logic              ok;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } s2_t;

  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [TS_W-1:0]  prod;
    logic [TOD_W-1:0] tod;
  } s3_t;

  // days of the month outside a leap february
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:    r = 5'd28;
      4'd4:    r = 5'd30;
      4'd6:    r = 5'd30;
      4'd9:    r = 5'd30;
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // days before the month in a year starting in march
  function automatic logic [8:0] mar_days(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/cdu_check.sv =====
// first stage: field range checks, year reciprocal products, time of day
`timescale 1ns / 1ps
module cdu_check import cdu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [YEAR_W-1:0] year,
  input  logic [3:0]        month,
  input  logic [4:0]        day,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [5:0]        second,
  output s1_t               s1
);

  s1_t s1_next;
  logic early;

  always_comb begin
    early = (month <= MON_FEB);
    s1_next.vld   = in_vld;
    s1_next.ok    = (year >= FIRST_YEAR) && (year <= LAST_YEAR) && (month != 4'd0) &&
                    (month <= 4'd12) && (day != 5'd0) && (hour <= 5'd23) &&
                    (minute <= 6'd59) && (second <= 6'd59);
    s1_next.year  = year;
    s1_next.yadj  = year - YEAR_W'(early);
    s1_next.py    = PROD_W'(year) * RECIP_100;
    s1_next.pya   = PROD_W'(s1_next.yadj) * RECIP_100;
    s1_next.month = month;
    s1_next.mp    = early ? (month + 4'd9) : (month - 4'd3);
    s1_next.day   = day;
    s1_next.tod   = TOD_W'(hour) * SEC_PER_HR + TOD_W'(minute) * SEC_PER_MIN +
                    TOD_W'(second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else begin
      s1.vld <= s1_next.vld;
    end
    s1.ok   <= s1_next.ok;
    s1.year <= s1_next.year;
    s1.yadj <= s1_next.yadj;
    s1.py   <= s1_next.py;
    s1.pya  <= s1_next.pya;
    s1.month <= s1_next.month;
    s1.mp   <= s1_next.mp;
    s1.day  <= s1_next.day;
    s1.tod  <= s1_next.tod;
  end

endmodule

// ===== hw/rtl/cdu_days.sv =====
// second stage: leap year and day of month check, day count since epoch
`timescale 1ns / 1ps
module cdu_days import cdu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  s1_t  s1,
  output s2_t  s2
);

  s2_t s2_next;
  logic [6:0] y100;
  logic [4:0] y400;
  logic [6:0] ya100;
  logic [4:0] ya400;
  logic       leap;
  logic [4:0] mlen;
  logic [23:0] days_full;

  always_comb begin
    y100  = s1.py[SH_100 +: 7];
    y400  = s1.py[SH_400 +: 5];
    ya100 = s1.pya[SH_100 +: 7];
    ya400 = s1.pya[SH_400 +: 5];
    leap  = ((s1.year[1:0] == 2'b00) && (s1.year != YEAR_W'(y100) * 14'd100)) ||
            (s1.year == YEAR_W'(y400) * 14'd400);
    mlen  = ((s1.month == MON_FEB) && leap) ? 5'd29 : month_len(s1.month);
    days_full = 24'(s1.yadj) * 24'd365 + 24'(s1.yadj[YEAR_W-1:2]) - 24'(ya100) +
                24'(ya400) + 24'(mar_days(s1.mp)) + 24'(s1.day) - DAYS_BIAS;
    s2_next.vld  = s1.vld;
    s2_next.ok   = s1.ok && (s1.day <= mlen);
    s2_next.days = days_full[DAYS_W-1:0];
    s2_next.tod  = s1.tod;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld <= 1'b0;
    end else begin
      s2.vld <= s2_next.vld;
    end
    s2.ok   <= s2_next.ok;
    s2.days <= s2_next.days;
    s2.tod  <= s2_next.tod;
  end

endmodule

// ===== hw/rtl/cdu_scale.sv =====
// third and fourth stages: days to seconds product, time of day add, result register
`timescale 1ns / 1ps
module cdu_scale import cdu_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  s2_t             s2,
  output logic            done,
  output logic [TS_W-1:0] unix_seconds,
  output logic            stamp_valid
);

  s3_t s3;
  logic [TS_W-1:0] ts_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.vld <= 1'b0;
    end else begin
      s3.vld <= s2.vld;
    end
    s3.ok   <= s2.ok;
    s3.prod <= TS_W'(s2.days) * SEC_PER_DAY;
    s3.tod  <= s2.tod;
  end

  always_comb begin
    ts_next = s3.ok ? (s3.prod + TS_W'(s3.tod)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3.vld;
    end
    unix_seconds <= ts_next;
    stamp_valid  <= s3.ok;
  end

endmodule

// ===== hw/rtl/civil_datetime_to_unix_seconds.sv =====
// top level: civil date and time to unix seconds, four stage pipeline
// done rises once a request has passed the s1, s2 and s3 registers and then the result register
// throughput: one request per cycle, busy stays low; the depth is set by the day count
// and the days by 86400 product, each with a stage of its own
// reset clears the stage valid bits only; requests in flight are dropped
// results cannot be held off: each is on the ports for exactly one cycle
`timescale 1ns / 1ps
module civil_datetime_to_unix_seconds import cdu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [YEAR_W-1:0] year,
  input  logic [3:0]        month,
  input  logic [4:0]        day,
  input  logic [4:0]        hour,
  input  logic [5:0]        minute,
  input  logic [5:0]        second,
  output logic              done,
  output logic [TS_W-1:0]   unix_seconds,
  output logic              stamp_valid
);

  s1_t s1;
  s2_t s2;

  assign busy = 1'b0;

  cdu_check u_check (
    .clk    (clk),
    .rst    (rst),
    .in_vld (start && !busy),
    .year   (year),
    .month  (month),
    .day    (day),
    .hour   (hour),
    .minute (minute),
    .second (second),
    .s1     (s1)
  );

  cdu_days u_days (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s2  (s2)
  );

  cdu_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .s2           (s2),
    .done         (done),
    .unix_seconds (unix_seconds),
    .stamp_valid  (stamp_valid)
  );

  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("request did not produce a result after four cycles");

  a_done_from_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 4))
    else $error("result without a matching request");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !stamp_valid) |-> (unix_seconds == '0))
    else $error("invalid result carries a nonzero timestamp");

  a_stage_chain: assert property (@(posedge clk) disable iff (rst)
    s2.vld |-> ##2 done)
    else $error("stage valid lost between day count and output");

endmodule
